// File: src/assert_macros.svh
// Assertion macros shared by the keyboard typematic RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kbt_pkg.sv
// Package for the keyboard typematic block: key codes, character constants,
// register indexes and the types passed between modules. No dependencies.
`default_nettype none

package kbt_pkg;

    localparam int MAX_KEYS = 6;
    localparam int LIST_MAX = MAX_KEYS + 1;
    localparam int CNT_W    = $clog2(LIST_MAX + 1);
    localparam int IDX_W    = $clog2(LIST_MAX);
    localparam int SPEC_W   = 9;

    // Key codes of a result beat.
    localparam logic [3:0] KEY_CHAR  = 4'd0;
    localparam logic [3:0] KEY_ENTER = 4'd1;
    localparam logic [3:0] KEY_BKSP  = 4'd2;
    localparam logic [3:0] KEY_DEL   = 4'd3;
    localparam logic [3:0] KEY_ESC   = 4'd4;
    localparam logic [3:0] KEY_TAB   = 4'd5;
    localparam logic [3:0] KEY_UP    = 4'd6;
    localparam logic [3:0] KEY_DOWN  = 4'd7;
    localparam logic [3:0] KEY_LEFT  = 4'd8;
    localparam logic [3:0] KEY_RIGHT = 4'd9;

    // Modifier bit positions.
    localparam int MOD_CTRL  = 0;
    localparam int MOD_SHIFT = 1;
    localparam int MOD_FN    = 4;

    // Character constants.
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'd32;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LESS     = 8'h3C;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;

    // Configuration register indexes and reset values.
    localparam logic       REG_DELAY = 1'b0;
    localparam logic       REG_RATE  = 1'b1;
    localparam logic [15:0] RST_DELAY = 16'd500;
    localparam logic [15:0] RST_RATE  = 16'd50;

    // Decoded snapshot: special-key flags (bit b is key code b+1) and the
    // character list that takes part in press detection.
    typedef struct packed {
        logic [SPEC_W-1:0]              spec;
        logic [LIST_MAX-1:0][7:0]       cur;
        logic [CNT_W-1:0]               ncur;
    } t_scan;

    typedef struct packed {
        logic [3:0] key_code;
        logic [7:0] char_code;
        logic       is_repeat;
    } t_event;

endpackage

`default_nettype wire

// File: src/kbt_scan_decode.sv
// Decodes one keyboard snapshot into special-key flags and a character list,
// applying the fn layer and the space rule. Depends on kbt_pkg.
`default_nettype none

module kbt_scan_decode
    import kbt_pkg::*;
(
    input  logic [4:0]  i_mods,
    input  logic        i_enter,
    input  logic        i_tab,
    input  logic        i_space,
    input  logic        i_del,
    input  logic [2:0]  i_count,
    input  logic [47:0] i_chars,
    output t_scan       o_scan
);

    always_comb begin
        logic       fn;
        logic [2:0] cnt_sat;
        logic [7:0] c;
        logic       has_space;
        logic       add_space;

        fn      = i_mods[MOD_FN];
        cnt_sat = (i_count > 3'(MAX_KEYS)) ? 3'(MAX_KEYS) : i_count;

        o_scan.spec = '0;
        has_space   = 1'b0;
        o_scan.spec[KEY_ENTER - 1] = i_enter;
        o_scan.spec[KEY_BKSP - 1]  = i_del & ~fn;
        o_scan.spec[KEY_DEL - 1]   = i_del & fn;
        o_scan.spec[KEY_TAB - 1]   = i_tab;

        for (int k = 0; k < MAX_KEYS; k++) begin
            c = i_chars[8*k +: 8];
            if (3'(k) < cnt_sat) begin
                if (fn) begin
                    case (c) inside
                        CH_BACKTICK, CH_TILDE: o_scan.spec[KEY_ESC - 1]   = 1'b1;
                        CH_SEMI, CH_COLON:     o_scan.spec[KEY_UP - 1]    = 1'b1;
                        CH_PERIOD, CH_GREATER: o_scan.spec[KEY_DOWN - 1]  = 1'b1;
                        CH_COMMA, CH_LESS:     o_scan.spec[KEY_LEFT - 1]  = 1'b1;
                        CH_SLASH, CH_QUESTION: o_scan.spec[KEY_RIGHT - 1] = 1'b1;
                        default: ;
                    endcase
                end else if (c == CH_SPACE) begin
                    has_space = 1'b1;
                end
            end
            // Slots past the count hold a space so the appended one lands
            // wherever the count ends.
            o_scan.cur[k] = (3'(k) < cnt_sat) ? c : CH_SPACE;
        end
        o_scan.cur[LIST_MAX-1] = CH_SPACE;

        add_space   = ~fn & i_space & ~has_space;
        o_scan.ncur = fn ? '0 : (CNT_W'(cnt_sat) + CNT_W'(add_space));
    end

endmodule

`default_nettype wire

// File: src/keyboard_event_typematic_top.sv
// Top level of the keyboard event converter with typematic auto-repeat:
// sequencer, history, configuration and output register. Uses kbt_pkg,
// kbt_scan_decode and assert_macros.svh.
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  ---------------------------------------
//   input     i_in_valid / o_in_stall    modifiers, key flags, chars, now_ms
//   output    o_out_valid / i_out_stall  key_code, char_code, mods, repeat, last
//   config    i_cfg_we                   i_cfg_idx, i_cfg_wdata (16 bit)
//
// A snapshot takes the beat, reports each rising special key, matches each
// listed character, runs the repeat timing check and flushes the last event,
// and an output stall can hold it. Unless the output stalls, the character
// phase matches one current character per cycle against all of the previous
// list at once; the repeat check runs both elapsed-time compares through a
// single 32-bit subtractor in consecutive cycles.
// Reset is synchronous and active low; it restores the register defaults and
// clears all history except the previous character bytes, which are only read
// below the previous count. A stalled output holds the sequencer whenever it
// has a new event ready and no room for the one it is holding back.
`default_nettype none

`include "assert_macros.svh"

module keyboard_event_typematic_top
    import kbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // snapshot channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [4:0]  i_in_modifiers,
    input  logic        i_enter_down,
    input  logic        i_tab_down,
    input  logic        i_space_down,
    input  logic        i_del_down,
    input  logic [2:0]  i_char_count,
    input  logic [47:0] i_chars_packed,
    input  logic [31:0] i_now_ms,
    // event channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_key_code,
    output logic [7:0]  o_char_code,
    output logic [4:0]  o_ev_modifiers,
    output logic        o_is_repeat,
    output logic        o_last_event
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPEC  = 3'd1;
    localparam logic [2:0] ST_CHAR  = 3'd2;
    localparam logic [2:0] ST_REP_A = 3'd3;
    localparam logic [2:0] ST_REP_B = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    // Control state.
    logic [2:0]          r_state,      n_state;
    logic [15:0]         r_delay,      n_delay;
    logic [15:0]         r_rate,       n_rate;
    logic [SPEC_W-1:0]   r_prev_spec,  n_prev_spec;
    logic [CNT_W-1:0]    r_prev_total, n_prev_total;
    logic [3:0]          r_held_code,  n_held_code;
    logic [7:0]          r_held_char,  n_held_char;
    logic                r_holding,    n_holding;
    logic [31:0]         r_hold_start, n_hold_start;
    logic [31:0]         r_last_rep,   n_last_rep;
    logic                r_pend_valid, n_pend_valid;
    logic                r_out_valid,  n_out_valid;

    // Working registers of the current snapshot.
    logic [4:0]             r_mods,   n_mods;
    logic [31:0]            r_now,    n_now;
    logic [SPEC_W-1:0]      r_spec,   n_spec;
    logic [SPEC_W-1:0]      r_rise,   n_rise;
    logic [LIST_MAX-1:0][7:0] r_cur,  n_cur;
    logic [CNT_W-1:0]       r_ncur,   n_ncur;
    logic [CNT_W-1:0]       r_idx,    n_idx;
    logic [LIST_MAX-1:0]    r_used,   n_used;
    logic                   r_dly_ok, n_dly_ok;
    t_event                 r_pend,   n_pend;
    t_event                 r_out,    n_out;
    logic [4:0]             r_out_mods, n_out_mods;
    logic                   r_out_last, n_out_last;

    // Previous character list; entries are only read below r_prev_total.
    logic [7:0] r_prev_list [LIST_MAX];

    t_scan scan;

    kbt_scan_decode u_decode (
        .i_mods  (i_in_modifiers),
        .i_enter (i_enter_down),
        .i_tab   (i_tab_down),
        .i_space (i_space_down),
        .i_del   (i_del_down),
        .i_count (i_char_count),
        .i_chars (i_chars_packed),
        .o_scan  (scan)
    );

    assign o_in_stall = (r_state != ST_IDLE);

    logic in_accept;
    logic out_free;
    logic can_emit;

    assign in_accept = i_in_valid & ~o_in_stall;
    // The output register can take a new beat this cycle.
    assign out_free  = ~r_out_valid | ~i_out_stall;
    // One event is always held back until it is known whether it is the last.
    assign can_emit  = ~r_pend_valid | out_free;

    // Lowest rising special key still to report.
    logic [3:0] rise_code;
    always_comb begin
        rise_code = KEY_CHAR;
        for (int i = SPEC_W - 1; i >= 0; i--) begin
            if (r_rise[i]) begin
                rise_code = 4'(i + 1);
            end
        end
    end

    // Compare bank: current character against every previous entry.
    logic [IDX_W-1:0]     cur_sel;
    logic [7:0]           cur_c;
    logic [LIST_MAX-1:0]  hit_first;
    logic                 hit_any;
    logic [7:0]           cur_low;

    assign cur_sel = (r_idx == r_ncur) ? '0 : r_idx[IDX_W-1:0];
    assign cur_c   = r_cur[cur_sel];

    always_comb begin
        hit_first = '0;
        hit_any   = 1'b0;
        for (int j = LIST_MAX - 1; j >= 0; j--) begin
            if ((CNT_W'(j) < r_prev_total) && !r_used[j] && (r_prev_list[j] == cur_c)) begin
                hit_first    = '0;
                hit_first[j] = 1'b1;
                hit_any      = 1'b1;
            end
        end
    end

    // Ctrl without shift reports capitals in lower case.
    assign cur_low = (r_mods[MOD_CTRL] && !r_mods[MOD_SHIFT] &&
                      cur_c >= CH_UPPER_A && cur_c <= CH_UPPER_Z)
                     ? (cur_c + CH_CASE_OFS) : cur_c;

    // Whether the held key is still down in this snapshot.
    logic still_held;
    logic any_held;
    always_comb begin
        still_held = 1'b0;
        if (r_held_code == KEY_CHAR) begin
            for (int j = 0; j < LIST_MAX; j++) begin
                if ((CNT_W'(j) < r_ncur) && (r_cur[j] == r_held_char)) begin
                    still_held = 1'b1;
                end
            end
        end else begin
            still_held = r_spec[r_held_code - 4'd1];
        end
    end
    assign any_held = (r_spec != '0) || (r_ncur != '0);

    // Shared elapsed-time unit: delay check in REP_A, rate check in REP_B.
    logic [31:0] sub_b;
    logic [31:0] elapsed;
    logic [15:0] limit;
    logic        elapsed_ok;

    assign sub_b      = (r_state == ST_REP_A) ? r_hold_start : r_last_rep;
    assign limit      = (r_state == ST_REP_A) ? r_delay : r_rate;
    assign elapsed    = r_now - sub_b;
    assign elapsed_ok = (elapsed >= {16'd0, limit});

    always_comb begin
        logic   do_emit;
        logic   fresh;
        t_event ev;

        n_state      = r_state;
        n_delay      = r_delay;
        n_rate       = r_rate;
        n_prev_spec  = r_prev_spec;
        n_prev_total = r_prev_total;
        n_held_code  = r_held_code;
        n_held_char  = r_held_char;
        n_holding    = r_holding;
        n_hold_start = r_hold_start;
        n_last_rep   = r_last_rep;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        n_mods       = r_mods;
        n_now        = r_now;
        n_spec       = r_spec;
        n_rise       = r_rise;
        n_cur        = r_cur;
        n_ncur       = r_ncur;
        n_idx        = r_idx;
        n_used       = r_used;
        n_dly_ok     = r_dly_ok;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_mods   = r_out_mods;
        n_out_last   = r_out_last;

        do_emit = 1'b0;
        fresh   = 1'b0;
        ev      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELAY: n_delay = i_cfg_wdata;
                REG_RATE:  n_rate  = i_cfg_wdata;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_mods      = i_in_modifiers;
                    n_now       = i_now_ms;
                    n_spec      = scan.spec;
                    n_rise      = scan.spec & ~r_prev_spec;
                    n_prev_spec = scan.spec;
                    n_cur       = scan.cur;
                    n_ncur      = scan.ncur;
                    n_idx       = '0;
                    n_used      = '0;
                    n_state     = ST_SPEC;
                end
            end
            ST_SPEC: begin
                if (r_rise == '0) begin
                    n_state = ST_CHAR;
                end else if (can_emit) begin
                    do_emit      = 1'b1;
                    fresh        = 1'b1;
                    ev.key_code  = rise_code;
                    ev.char_code = 8'd0;
                    ev.is_repeat = 1'b0;
                    n_rise       = r_rise & (r_rise - 1'b1);
                end
            end
            ST_CHAR: begin
                if (r_idx == r_ncur) begin
                    n_state = r_pend_valid ? ST_FLUSH : ST_REP_A;
                end else if (hit_any) begin
                    n_used = r_used | hit_first;
                    n_idx  = r_idx + 1'b1;
                end else if (can_emit) begin
                    do_emit      = 1'b1;
                    fresh        = 1'b1;
                    ev.key_code  = KEY_CHAR;
                    ev.char_code = cur_low;
                    ev.is_repeat = 1'b0;
                    n_idx        = r_idx + 1'b1;
                end
            end
            ST_REP_A: begin
                n_state = ST_FLUSH;
                if (r_holding) begin
                    if (!any_held || !still_held) begin
                        n_holding = 1'b0;
                    end else if (r_held_code != KEY_ENTER && r_held_code != KEY_ESC &&
                                 r_held_code != KEY_TAB) begin
                        n_dly_ok = elapsed_ok;
                        n_state  = ST_REP_B;
                    end
                end
            end
            ST_REP_B: begin
                if (r_dly_ok && elapsed_ok) begin
                    do_emit      = 1'b1;
                    ev.key_code  = r_held_code;
                    ev.char_code = r_held_char;
                    ev.is_repeat = 1'b1;
                    n_last_rep   = r_now;
                end
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_prev_total = r_ncur;
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out_mods   = r_mods;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // A new event pushes the one held back out to the output register.
        if (do_emit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_pend;
                n_out_mods  = r_mods;
                n_out_last  = 1'b0;
            end
            n_pend       = ev;
            n_pend_valid = 1'b1;
        end

        // A fresh press becomes the held key and restarts its timing.
        if (fresh) begin
            n_held_code  = ev.key_code;
            n_held_char  = ev.char_code;
            n_holding    = 1'b1;
            n_hold_start = r_now;
            n_last_rep   = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_delay      <= RST_DELAY;
            r_rate       <= RST_RATE;
            r_prev_spec  <= '0;
            r_prev_total <= '0;
            r_held_code  <= KEY_CHAR;
            r_held_char  <= 8'd0;
            r_holding    <= 1'b0;
            r_hold_start <= 32'd0;
            r_last_rep   <= 32'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_delay      <= n_delay;
            r_rate       <= n_rate;
            r_prev_spec  <= n_prev_spec;
            r_prev_total <= n_prev_total;
            r_held_code  <= n_held_code;
            r_held_char  <= n_held_char;
            r_holding    <= n_holding;
            r_hold_start <= n_hold_start;
            r_last_rep   <= n_last_rep;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mods     <= n_mods;
        r_now      <= n_now;
        r_spec     <= n_spec;
        r_rise     <= n_rise;
        r_cur      <= n_cur;
        r_ncur     <= n_ncur;
        r_idx      <= n_idx;
        r_used     <= n_used;
        r_dly_ok   <= n_dly_ok;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_mods <= n_out_mods;
        r_out_last <= n_out_last;
    end

    // The current list becomes history once the snapshot is finished.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FLUSH) begin
            for (int k = 0; k < LIST_MAX; k++) begin
                if (CNT_W'(k) < r_ncur) begin
                    r_prev_list[k] <= r_cur[k];
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_code     = r_out.key_code;
    assign o_char_code    = r_out.char_code;
    assign o_is_repeat    = r_out.is_repeat;
    assign o_ev_modifiers = r_out_mods;
    assign o_last_event   = r_out_last;

    `KBT_ASSERT_NXT(a_accept_starts, in_accept, r_state == ST_SPEC, "accepted beat did not start")
    `KBT_ASSERT_IMP(a_idle_no_pend, r_state == ST_IDLE, !r_pend_valid, "event left behind at idle")
    `KBT_ASSERT_IMP(a_idx_bound, r_state == ST_CHAR, r_idx <= r_ncur, "char index past list")
    `KBT_ASSERT_IMP(a_repeat_holding, r_pend_valid && r_pend.is_repeat, r_holding, "repeat without held key")
    `KBT_ASSERT_IMP(a_repeat_alone, o_out_valid && o_is_repeat, o_last_event, "repeat not the only event")

endmodule

`default_nettype wire
